// ----- rtl/core/bba_pkg.sv -----
// Package with shared constants, codes and types of the buddy block allocator.
package bba_pkg;

    localparam int          TREE_LEVELS_DEF = 8;
    localparam logic [15:0] ROOT_SIZE_RST   = 16'd1024;

    typedef enum logic [1:0] {
        ST_ALLOC    = 2'd0,
        ST_FREED    = 2'd1,
        ST_NO_FIT   = 2'd2,
        ST_NO_OWNER = 2'd3
    } t_status;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        PH_ALLOC,
        PH_FREE,
        PH_TALLY
    } t_phase;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_SPLIT_L,
        S_SPLIT_R,
        S_ASC,
        S_MERGE_RD,
        S_MERGE_EV,
        S_TALLY,
        S_DONE
    } t_state;

    // One tree node as stored in the node memory.
    typedef struct packed {
        logic        split;
        logic [7:0]  owner;
        logic [15:0] req;
    } t_node;

endpackage

// ----- rtl/core/bba_if.sv -----
// Channel interfaces of the buddy block allocator: config, request and response.
interface bba_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] root_size;

    modport source (output valid, output root_size, input ready);
    modport sink   (input valid, input root_size, output ready);
endinterface

interface bba_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  owner_id;
    logic [15:0] request_size;

    modport source (output valid, output req_type, output owner_id, output request_size,
                    input ready);
    modport sink   (input valid, input req_type, input owner_id, input request_size,
                    output ready);
endinterface

interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_size;
    logic [15:0] used_total;
    logic [15:0] waste_total;

    modport source (output valid, output status, output granted_size, output used_total,
                    output waste_total, input ready);
    modport sink   (input valid, input status, input granted_size, input used_total,
                    input waste_total, output ready);
endinterface

// ----- rtl/core/buddy_block_allocator.sv -----
// Buddy block allocator over a binary tree of blocks held in one node memory.
//
// Channels: i_cfg writes root_size (always ready). i_req carries one allocate
// or free beat; o_rsp returns one beat per request with status, the granted
// or released size and the running used and waste totals.
// Each request walks the node tree held in a memory with a registered read,
// one node per read and decide pair of states. An allocate or free visits
// up to 2^TREE_LEVELS-1 nodes, plus an ascend step per level climbed, a free
// then merges upward with a merge read and decide per level, and every
// request ends with a full tally walk of the held blocks.
// One request is in work at a time; i_req is ready only while idle.
// After reset a clearing pass writes every node, during which no request is
// taken; config writes are taken as ever.
// The result register holds a beat until o_rsp.ready; while it waits the next
// request may be accepted and worked, and its result waits for the slot.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bba_cfg_if.sink    i_cfg,
    bba_req_if.sink    i_req,
    bba_rsp_if.source  o_rsp
);

    localparam int NODE_CNT = (1 << TREE_LEVELS) - 1;
    localparam int AW       = TREE_LEVELS;
    localparam int DW       = $clog2(TREE_LEVELS + 1);
    localparam logic [AW-1:0] LAST_NODE = AW'(NODE_CNT - 1);
    localparam logic [DW-1:0] DEEPEST   = DW'(TREE_LEVELS - 1);

    t_node mem [NODE_CNT];

    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [15:0]   r_root;
    logic [AW-1:0] r_node, n_node;
    logic [DW-1:0] r_depth, n_depth;
    t_node         r_rdata;
    logic          r_type;
    logic [7:0]    r_owner;
    logic [15:0]   r_size;
    t_status       r_status, n_status;
    logic [15:0]   r_granted, n_granted;
    logic [15:0]   r_used, n_used;
    logic [15:0]   r_waste, n_waste;
    logic          r_out_valid;
    t_status       r_out_status;
    logic [15:0]   r_out_granted, r_out_used, r_out_waste;

    logic          mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    t_node         mem_wdata;

    logic [15:0]   blk, half;
    logic          can_split, at_root, is_left;
    logic [AW-1:0] left_ch, parent, sibling;
    logic          req_acc, out_load;

    assign blk       = r_root >> r_depth;
    assign half      = blk >> 1;
    assign can_split = (r_depth < DEEPEST);
    assign at_root   = (r_node == '0);
    assign is_left   = r_node[0];
    assign left_ch   = {r_node[AW-2:0], 1'b1};
    assign parent    = (r_node - AW'(1)) >> 1;
    assign sibling   = is_left ? r_node + AW'(1) : r_node - AW'(1);

    assign req_acc   = i_req.valid && i_req.ready;
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);

    // Node memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (r_node == LAST_NODE) n_state = S_IDLE;
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.owner_id == '0 ||
                        (i_req.req_type == REQ_ALLOC && i_req.request_size == '0)) begin
                        n_state = S_TALLY;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:       n_state = S_EVAL;
            S_EVAL: begin
                n_state = S_ASC;
                case (r_phase)
                    PH_ALLOC: begin
                        if (r_rdata.owner != '0) begin
                            n_state = S_ASC;
                        end else if (r_size <= half && can_split) begin
                            n_state = r_rdata.split ? S_RD : S_SPLIT_L;
                        end else if (!r_rdata.split && r_size <= blk) begin
                            n_state = S_TALLY;
                        end
                    end
                    PH_FREE: begin
                        if (!r_rdata.split) begin
                            if (r_rdata.owner == r_owner) begin
                                n_state = at_root ? S_TALLY : S_MERGE_RD;
                            end
                        end else if (can_split) begin
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        if (r_rdata.split && can_split) n_state = S_RD;
                    end
                endcase
            end
            S_SPLIT_L:  n_state = S_SPLIT_R;
            S_SPLIT_R:  n_state = S_RD;
            S_ASC: begin
                if (at_root) begin
                    n_state = (r_phase == PH_TALLY) ? S_DONE : S_TALLY;
                end else if (is_left) begin
                    n_state = S_RD;
                end
            end
            S_MERGE_RD: n_state = S_MERGE_EV;
            S_MERGE_EV: begin
                if (!r_rdata.split && r_rdata.owner == '0 && parent != '0) begin
                    n_state = S_MERGE_RD;
                end else begin
                    n_state = S_TALLY;
                end
            end
            S_TALLY:    n_state = S_RD;
            S_DONE:     if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_phase   = r_phase;
        n_node    = r_node;
        n_depth   = r_depth;
        n_status  = r_status;
        n_granted = r_granted;
        n_used    = r_used;
        n_waste   = r_waste;
        mem_re    = 1'b0;
        mem_raddr = r_node;
        mem_we    = 1'b0;
        mem_waddr = r_node;
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_node = (r_node == LAST_NODE) ? '0 : r_node + AW'(1);
            end
            S_IDLE: begin
                n_node    = '0;
                n_depth   = '0;
                n_granted = '0;
                n_phase   = (i_req.req_type == REQ_FREE) ? PH_FREE : PH_ALLOC;
                n_status  = (i_req.req_type == REQ_FREE) ? ST_NO_OWNER : ST_NO_FIT;
            end
            S_RD: begin
                mem_re = 1'b1;
            end
            S_EVAL: begin
                case (r_phase)
                    PH_ALLOC: begin
                        if (r_rdata.owner == '0) begin
                            if (r_size <= half && can_split) begin
                                if (!r_rdata.split) begin
                                    mem_we    = 1'b1;
                                    mem_wdata = '{split: 1'b1, owner: '0, req: r_rdata.req};
                                end else begin
                                    n_node  = left_ch;
                                    n_depth = r_depth + DW'(1);
                                end
                            end else if (!r_rdata.split && r_size <= blk) begin
                                mem_we    = 1'b1;
                                mem_wdata = '{split: 1'b0, owner: r_owner, req: r_size};
                                n_status  = ST_ALLOC;
                                n_granted = blk;
                            end
                        end
                    end
                    PH_FREE: begin
                        if (!r_rdata.split) begin
                            if (r_rdata.owner == r_owner) begin
                                mem_we    = 1'b1;
                                n_status  = ST_FREED;
                                n_granted = blk;
                            end
                        end else if (can_split) begin
                            n_node  = left_ch;
                            n_depth = r_depth + DW'(1);
                        end
                    end
                    default: begin
                        if (r_rdata.split && can_split) begin
                            n_node  = left_ch;
                            n_depth = r_depth + DW'(1);
                        end else if (!r_rdata.split && r_rdata.owner != '0) begin
                            n_used = r_used + blk;
                            if (blk > r_rdata.req) n_waste = r_waste + (blk - r_rdata.req);
                        end
                    end
                endcase
            end
            S_SPLIT_L: begin
                mem_we    = 1'b1;
                mem_waddr = left_ch;
            end
            S_SPLIT_R: begin
                mem_we    = 1'b1;
                mem_waddr = left_ch + AW'(1);
                n_node    = left_ch;
                n_depth   = r_depth + DW'(1);
            end
            S_ASC: begin
                if (!at_root) begin
                    if (is_left) begin
                        n_node = r_node + AW'(1);
                    end else begin
                        n_node  = parent;
                        n_depth = r_depth - DW'(1);
                    end
                end
            end
            S_MERGE_RD: begin
                mem_re    = 1'b1;
                mem_raddr = sibling;
            end
            S_MERGE_EV: begin
                if (!r_rdata.split && r_rdata.owner == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = parent;
                    n_node    = parent;
                    n_depth   = r_depth - DW'(1);
                end
            end
            S_TALLY: begin
                n_phase = PH_TALLY;
                n_node  = '0;
                n_depth = '0;
                n_used  = '0;
                n_waste = '0;
            end
            default: ;
        endcase
    end

    // Control and work registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_TALLY;
            r_node      <= '0;
            r_depth     <= '0;
            r_root      <= ROOT_SIZE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_node  <= n_node;
            r_depth <= n_depth;
            if (i_cfg.valid) r_root <= i_cfg.root_size;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_granted <= n_granted;
        r_used    <= n_used;
        r_waste   <= n_waste;
        if (req_acc) begin
            r_type  <= i_req.req_type;
            r_owner <= i_req.owner_id;
            r_size  <= i_req.request_size;
        end
        if (out_load) begin
            r_out_status  <= r_status;
            r_out_granted <= r_granted;
            r_out_used    <= r_used;
            r_out_waste   <= r_waste;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.granted_size = r_out_granted;
    assign o_rsp.used_total   = r_out_used;
    assign o_rsp.waste_total  = r_out_waste;

    // The walk never goes below the deepest level.
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEEPEST)
        else $error("walk depth beyond deepest level");

    // No request is taken during the clearing pass.
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !i_req.ready)
        else $error("request taken while clearing");

    // A granted allocation always has a nonzero block size.
    a_grant_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_status == ST_ALLOC |-> r_granted != '0)
        else $error("allocation granted with zero size");

    // Only allocate requests can end allocated, only free requests freed.
    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> ((r_status == ST_ALLOC || r_status == ST_NO_FIT) == (r_type == REQ_ALLOC)))
        else $error("status does not match request type");

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the buddy block allocator.
`timescale 1ns / 1ps

module tb
    import bba_pkg::*;
();

    localparam int LEVELS     = TREE_LEVELS_DEF;
    localparam int NODES      = (1 << LEVELS) - 1;
    localparam int MAX_CYCLES = 10000000;

    logic i_clk;
    logic i_rst_n;

    bba_cfg_if cfg_ch ();
    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    buddy_block_allocator #(.TREE_LEVELS(LEVELS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // One expected response beat.
    typedef struct {
        t_status     status;
        logic [15:0] granted;
        logic [15:0] used;
        logic [15:0] waste;
    } t_outcome;

    // Shadow copy of the allocator tree.
    logic        tree_split [NODES];
    logic [7:0]  tree_owner [NODES];
    logic [15:0] tree_req   [NODES];
    logic [15:0] shadow_root;

    t_outcome outcome_q[$];
    int       error_count;
    int       beats_checked;
    int       cycle_count;
    int       alloc_sent;
    int       free_sent;
    bit       stall_enable;
    bit       burst_mode;
    int       gap_left;

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] node_size(int depth);
        return shadow_root >> depth;
    endfunction

    // Left-first search that splits free leaves on the way down.
    function automatic bit place_block(int n, int depth, logic [7:0] owner,
                                       logic [15:0] amount, inout logic [15:0] got);
        logic [15:0] s;
        int          l;
        int          r;
        s = node_size(depth);
        if (n >= NODES || tree_owner[n] != 8'd0) return 1'b0;
        if (amount <= s / 2 && depth + 1 < LEVELS) begin
            l = 2 * n + 1;
            r = 2 * n + 2;
            if (!tree_split[n]) begin
                tree_split[n] = 1'b1;
                tree_split[l] = 1'b0; tree_owner[l] = 8'd0; tree_req[l] = 16'd0;
                tree_split[r] = 1'b0; tree_owner[r] = 8'd0; tree_req[r] = 16'd0;
            end
            if (place_block(l, depth + 1, owner, amount, got)) return 1'b1;
            return place_block(r, depth + 1, owner, amount, got);
        end
        if (!tree_split[n] && amount <= s) begin
            tree_owner[n] = owner;
            tree_req[n]   = amount;
            got           = s;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Release the first leaf held by the owner, merging free buddies upward.
    function automatic bit release_block(int n, int depth, logic [7:0] owner,
                                         inout logic [15:0] got);
        bit found;
        int l;
        int r;
        if (n >= NODES) return 1'b0;
        if (!tree_split[n]) begin
            if (tree_owner[n] == owner) begin
                tree_owner[n] = 8'd0;
                tree_req[n]   = 16'd0;
                got           = node_size(depth);
                return 1'b1;
            end
            return 1'b0;
        end
        if (depth + 1 >= LEVELS) return 1'b0;
        l = 2 * n + 1;
        r = 2 * n + 2;
        found = release_block(l, depth + 1, owner, got);
        if (!found) found = release_block(r, depth + 1, owner, got);
        if (found && !tree_split[l] && tree_owner[l] == 8'd0
                  && !tree_split[r] && tree_owner[r] == 8'd0)
            tree_split[n] = 1'b0;
        return found;
    endfunction

    // Sum held block sizes and their unused parts.
    function automatic void sum_held(int n, int depth, inout int used, inout int waste);
        int s;
        if (n >= NODES) return;
        if (tree_split[n] && depth + 1 < LEVELS) begin
            sum_held(2 * n + 1, depth + 1, used, waste);
            sum_held(2 * n + 2, depth + 1, used, waste);
        end else if (!tree_split[n] && tree_owner[n] != 8'd0) begin
            s = node_size(depth);
            used += s;
            if (s > tree_req[n]) waste += s - tree_req[n];
        end
    endfunction

    function automatic t_outcome predict_outcome(logic kind, logic [7:0] owner,
                                                 logic [15:0] amount);
        t_outcome    o;
        logic [15:0] got;
        int          used;
        int          waste;
        got   = 16'd0;
        used  = 0;
        waste = 0;
        if (kind == REQ_ALLOC) begin
            if (amount != 0 && owner != 0 && place_block(0, 0, owner, amount, got))
                o.status = ST_ALLOC;
            else begin
                o.status = ST_NO_FIT;
                got      = 16'd0;
            end
        end else begin
            if (owner != 0 && release_block(0, 0, owner, got))
                o.status = ST_FREED;
            else begin
                o.status = ST_NO_OWNER;
                got      = 16'd0;
            end
        end
        sum_held(0, 0, used, waste);
        o.granted = got;
        o.used    = used[15:0];
        o.waste   = waste[15:0];
        return o;
    endfunction

    // Send one request beat, with bursty sender gaps in burst mode. Valid stays high after
    // the beat is taken until the next beat or a gap replaces it.
    task automatic send_request(logic kind, logic [7:0] owner, logic [15:0] amount);
        if (burst_mode) begin
            if (gap_left == 0 && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
            if (gap_left > 0) req_ch.valid <= 1'b0;
            while (gap_left > 0) begin
                @(posedge i_clk);
                gap_left--;
            end
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.owner_id     <= owner;
        req_ch.request_size <= amount;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        outcome_q.push_back(predict_outcome(kind, owner, amount));
        if (kind == REQ_ALLOC) alloc_sent++; else free_sent++;
    endtask

    // Write root_size once the block has drained.
    task automatic write_root(logic [15:0] value);
        req_ch.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.root_size <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        shadow_root = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // Free everything still held so a phase starts clean.
    task automatic drain_owners();
        for (int n = 0; n < NODES; n++)
            while (!tree_split[n] && tree_owner[n] != 8'd0)
                send_request(REQ_FREE, tree_owner[n], 16'd0);
    endtask

    // Receiver stall pattern and response checking.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                beats_checked++;
                if (outcome_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) $display("unexpected response beat");
                end else begin
                    want = outcome_q.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.granted_size !== want.granted
                        || rsp_ch.used_total !== want.used
                        || rsp_ch.waste_total !== want.waste) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("beat %0d: expected st=%0d g=%0d u=%0d w=%0d, got st=%0d g=%0d u=%0d w=%0d",
                                     beats_checked, want.status, want.granted, want.used,
                                     want.waste, rsp_ch.status, rsp_ch.granted_size,
                                     rsp_ch.used_total, rsp_ch.waste_total);
                    end
                end
            end
            rsp_ch.ready <= stall_enable ? (cycle_count % 7 < 4 || $urandom_range(0, 3) == 0)
                                         : 1'b1;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("buddy_block_allocator: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(REQ_ALLOC, 8'd1, 16'd0);
        send_request(REQ_ALLOC, 8'd0, 16'd8);
        send_request(REQ_FREE, 8'd0, 16'd0);
        send_request(REQ_FREE, 8'd9, 16'd0);
        send_request(REQ_ALLOC, 8'd255, 16'd1);
        send_request(REQ_ALLOC, 8'd2, 16'd1024);
        send_request(REQ_ALLOC, 8'd3, 16'd65535);
        send_request(REQ_ALLOC, 8'd4, 16'd300);
        send_request(REQ_ALLOC, 8'd4, 16'd5);
        send_request(REQ_FREE, 8'd4, 16'hFFFF);
        send_request(REQ_FREE, 8'd255, 16'd0);
        send_request(REQ_FREE, 8'd4, 16'd0);
        send_request(REQ_ALLOC, 8'd5, 16'd512);
        send_request(REQ_ALLOC, 8'd6, 16'd512);
        send_request(REQ_ALLOC, 8'd7, 16'd1);
        send_request(REQ_FREE, 8'd5, 16'd0);
        send_request(REQ_FREE, 8'd6, 16'd0);
        send_request(REQ_FREE, 8'd6, 16'd0);
    endtask

    task automatic test_resize_held();
        send_request(REQ_ALLOC, 8'd10, 16'd100);
        send_request(REQ_ALLOC, 8'd11, 16'd3);
        write_root(16'd64);
        send_request(REQ_ALLOC, 8'd12, 16'd2);
        write_root(16'd0);
        send_request(REQ_ALLOC, 8'd13, 16'd1);
        send_request(REQ_FREE, 8'd10, 16'd0);
        write_root(16'd65535);
        drain_owners();
    endtask

    task automatic test_random(int count, logic [15:0] root, int max_amount);
        logic [7:0]  owner;
        logic [15:0] amount;
        write_root(root);
        for (int i = 0; i < count; i++) begin
            owner  = 8'($urandom_range(1, 12));
            if ($urandom_range(0, 31) == 0) owner = 8'($urandom_range(0, 255));
            amount = 16'($urandom_range(1, max_amount));
            if ($urandom_range(0, 15) == 0) amount = 16'($urandom);
            if ($urandom_range(0, 9) < 6) send_request(REQ_ALLOC, owner, amount);
            else send_request(REQ_FREE, owner, 16'($urandom));
        end
        drain_owners();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.root_size = 16'd0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_ALLOC;
        req_ch.owner_id  = 8'd0;
        req_ch.request_size = 16'd0;
        error_count = 0; beats_checked = 0; cycle_count = 0;
        alloc_sent = 0; free_sent = 0; gap_left = 0;
        stall_enable = 1'b0;
        burst_mode   = 1'b0;
        shadow_root  = ROOT_SIZE_RST;
        for (int n = 0; n < NODES; n++) begin
            tree_split[n] = 1'b0; tree_owner[n] = 8'd0; tree_req[n] = 16'd0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        stall_enable = 1'b1;
        burst_mode   = 1'b1;
        test_resize_held();
        test_random(150, 16'd1024, 300);
        test_random(100, 16'd1, 2);
        test_random(120, 16'd65535, 65535);
        stall_enable = 1'b0;
        burst_mode   = 1'b0;
        test_random(80, 16'd200, 60);

        req_ch.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (2100) @(posedge i_clk);
        $display("Ran %0d allocate and %0d free requests, %0d response beats checked,",
                 alloc_sent, free_sent, beats_checked);
        $display("over several root sizes including 0, 1 and 65535.");
        if (error_count == 0 && outcome_q.size() == 0)
            $display("buddy_block_allocator: match");
        else
            $display("buddy_block_allocator: mismatch");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/bba_pkg.sv
rtl/core/bba_if.sv
rtl/core/buddy_block_allocator.sv
bench/tb.sv
